// ===== src/adaptive_pi_controller_defines.svh =====
// ---------------------------------------------------------------------------
// Adaptive PI controller assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ADAPTIVE_PI_CONTROLLER_DEFINES_SVH
`define ADAPTIVE_PI_CONTROLLER_DEFINES_SVH
`ifndef SYNTHESIS
`define APC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define APC_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define APC_ASSERT(label, clk, rst_n, prop, msg)
`define APC_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ===== src/apc_pkg.sv =====
// ---------------------------------------------------------------------------
// apc_pkg
// Shared types, constants and saturating helpers of the adaptive PI loop.
// ---------------------------------------------------------------------------
package apc_pkg;

  localparam int FracBits = 16;
  localparam int C40 = ((4 << FracBits) + 5) / 10;
  localparam logic signed [31:0] KpFixed = 32'sd25 <<< FracBits;
  localparam logic signed [31:0] KiFixed = 32'sd10 <<< FracBits;

  typedef enum logic [1:0] {
    CMD_STEP   = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_RELOAD = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_ADAPT  = 2'd0,
    MODE_FIXED  = 2'd1,
    MODE_FROZEN = 2'd2,
    MODE_HOLD   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    REG_INIT_P   = 3'd0,
    REG_INIT_I   = 3'd1,
    REG_RATE     = 3'd2,
    REG_LEAK     = 3'd3,
    REG_LIMIT    = 3'd4,
    REG_MODE     = 3'd5,
    REG_P_BOUNDS = 3'd6,
    REG_I_BOUNDS = 3'd7
  } reg_e;

  // Datapath micro-operations issued by the sequencer.
  typedef enum logic [4:0] {
    OP_ERR,      // e = sat(sp - ms); ilim = lim*C40
    OP_ILIM,     // latch ilim product, prod kp*e
    OP_T_PE,     // a = qmul(kp,e); prod ki*I
    OP_T_IE,     // trial = a + qmul; sat flag; prod e*dt
    OP_INTEG,    // I update with e*dt product
    OP_D_KI,     // prod ki*I(new)
    OP_DRIVE,    // drive
    OP_SG,       // prod sigma*gamma
    OP_GE,       // sg latch; prod g*e
    OP_GEE,      // prod (g*e)*e
    OP_SGKP,     // t1 latch; prod sg*kp
    OP_DKP,      // dkp; prod dkp*dt
    OP_GI,       // newkp; prod g*I
    OP_GIE,      // prod (g*I)*e
    OP_SGKI,     // t1 latch; prod sg*ki
    OP_DKI,      // dki; prod dki*dt
    OP_NEWKI,    // newki, commit gains
    OP_FIXED,
    OP_CLEAR,
    OP_RELOAD,
    OP_NONE
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic  load;   // capture input beat
    op_e   op;
  } ctrl_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [31:0] x,
                                                  input logic signed [31:0] lo,
                                                  input logic signed [31:0] hi);
    logic signed [31:0] r;
    r = x;
    if (r < lo) r = lo;
    if (r > hi) r = hi;
    return r;
  endfunction

endpackage

// ===== src/adaptive_pi_controller.sv =====
// ---------------------------------------------------------------------------
// adaptive_pi_controller
// Adaptive PI loop in signed Q16.16 with sigma-modification gain update.
// ---------------------------------------------------------------------------
// One beat on the slave side gives one result beat on the master side. A
// sequencer drives a single shared 33x33 multiplier through the products of
// the step one per cycle. A control step ends after the drive in frozen or
// hold mode; fixed mode then loads the fixed gains and adaptive mode runs the
// gain update. Clear, reload and the no-op command run only their own operation.
// One beat is in flight at a time: the next beat is accepted the cycle after
// the result has been taken. Configuration writes are expected only while
// the block is idle.
// ---------------------------------------------------------------------------
`include "adaptive_pi_controller_defines.svh"

module adaptive_pi_controller import apc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: command[1:0], setpoint[33:2], measured[65:34], time_step[81:66]
  input  logic [87:0]  s_axis_tdata,
  // tuser: on_ground
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: drive[31:0], p_gain[63:32], i_gain[95:64]
  output logic [95:0]  m_axis_tdata,
  // tuser: trial_saturated
  output logic         m_axis_tuser,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [63:0]  cfg_data_i
);

  ctrl_t              ctrl;
  logic [1:0]         mode;
  logic signed [31:0] drive, kp, ki;
  logic               tsat;

  // Always take configuration beats.
  assign cfg_ready_o = 1'b1;

  apc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .cmd_i       (s_axis_tdata[1:0]),
    .mode_i      (mode),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .ctrl_o      (ctrl)
  );

  apc_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_idx_i   (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .ctrl_i      (ctrl),
    .setpoint_i  (s_axis_tdata[33:2]),
    .measured_i  (s_axis_tdata[65:34]),
    .time_step_i (s_axis_tdata[81:66]),
    .on_ground_i (s_axis_tuser),
    .mode_o      (mode),
    .drive_o     (drive),
    .trial_sat_o (tsat),
    .p_gain_o    (kp),
    .i_gain_o    (ki)
  );

  assign m_axis_tdata = {ki, kp, drive};
  assign m_axis_tuser = tsat;

  // Never accept and present a result in the same cycle.
  `APC_ASSERT_NEVER(a_no_overlap, clk_i, rst_ni, s_axis_tready && m_axis_tvalid,
                    "input ready while result pending")
  // A taken result returns the block to accepting input.
  `APC_ASSERT(a_ret_idle, clk_i, rst_ni, (m_axis_tvalid && m_axis_tready) |=> s_axis_tready,
              "block did not return to idle")
  // The drive never exceeds the configured limit while presented.
  `APC_ASSERT(a_drive_lim, clk_i, rst_ni,
              m_axis_tvalid |-> (drive <= $signed({1'b0, u_dp.lim_q}) ||
                                 drive == 32'sd0),
              "drive above limit")

endmodule

// ===== src/apc_ctrl.sv =====
// ---------------------------------------------------------------------------
// apc_ctrl
// Sequencer: walks the micro-operation list for one beat.
// ---------------------------------------------------------------------------
module apc_ctrl import apc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] cmd_i,
  input  logic [1:0] mode_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output ctrl_t      ctrl_o
);

  state_e state_q, state_d;
  op_e    op_q, op_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_NONE;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_RUN;
          case (cmd_e'(cmd_i))
            CMD_STEP:   op_d = OP_ERR;
            CMD_CLEAR:  op_d = OP_CLEAR;
            CMD_RELOAD: op_d = OP_RELOAD;
            default:    op_d = OP_NONE;
          endcase
        end
      end
      ST_RUN: begin
        case (op_q)
          OP_DRIVE: begin
            if (mode_e'(mode_i) == MODE_ADAPT) op_d = OP_SG;
            else if (mode_e'(mode_i) == MODE_FIXED) op_d = OP_FIXED;
            else begin
              op_d    = OP_NONE;
              state_d = ST_OUT;
            end
          end
          OP_NEWKI, OP_FIXED, OP_CLEAR, OP_RELOAD, OP_NONE: begin
            op_d    = OP_NONE;
            state_d = ST_OUT;
          end
          default: op_d = op_e'(op_q + 5'd1);
        endcase
      end
      ST_OUT: begin
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    out_valid_o = (state_q == ST_OUT);
    ctrl_o.load = (state_q == ST_IDLE) && in_valid_i;
    ctrl_o.op   = (state_q == ST_RUN) ? op_q : OP_NONE;
  end

endmodule

// ===== src/apc_datapath.sv =====
// ---------------------------------------------------------------------------
// apc_datapath
// Loop state, configuration registers and one shared 33x33 multiplier.
// ---------------------------------------------------------------------------
module apc_datapath import apc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [63:0]        cfg_data_i,
  input  ctrl_t              ctrl_i,
  input  logic signed [31:0] setpoint_i,
  input  logic signed [31:0] measured_i,
  input  logic [15:0]        time_step_i,
  input  logic               on_ground_i,
  output logic [1:0]         mode_o,
  output logic signed [31:0] drive_o,
  output logic               trial_sat_o,
  output logic signed [31:0] p_gain_o,
  output logic signed [31:0] i_gain_o
);

  logic [30:0] init_p_q, init_i_q, rate_q, leak_q, lim_q;
  logic [1:0]  mode_q;
  logic [63:0] pb_q, ib_q;

  logic signed [31:0] integ_q, integ_d, kp_q, kp_d, ki_q, ki_d;
  logic signed [31:0] sp_q, ms_q, e_q, e_d, a_q, a_d, t_q, t_d, sg_q, sg_d;
  logic signed [31:0] ilim_q, ilim_d, drive_q, drive_d, nkp_q, nkp_d;
  logic [15:0]        ts_q;
  logic               gnd_q, sat_q, sat_d;
  logic signed [63:0] prod_q, prod_d;
  logic signed [65:0] prod_full;
  logic signed [32:0] ma;
  logic signed [32:0] mb;

  // Product view: qmul result and dt result of the last registered product.
  logic signed [31:0] pq, pdt, lim_s, dsum;
  assign pq    = sat32(66'(prod_q >>> FracBits));
  assign pdt   = sat32(66'(prod_q >>> 16));
  assign lim_s = $signed({1'b0, lim_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_p_q <= '0; init_i_q <= '0; rate_q <= '0; leak_q <= '0; lim_q <= '0;
      mode_q   <= MODE_FIXED;
      pb_q     <= '0; ib_q <= '0;
      integ_q  <= '0; kp_q <= '0; ki_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (reg_e'(cfg_idx_i))
          REG_INIT_P:   init_p_q <= cfg_data_i[30:0];
          REG_INIT_I:   init_i_q <= cfg_data_i[30:0];
          REG_RATE:     rate_q   <= cfg_data_i[30:0];
          REG_LEAK:     leak_q   <= cfg_data_i[30:0];
          REG_LIMIT:    lim_q    <= cfg_data_i[30:0];
          REG_MODE:     mode_q   <= cfg_data_i[1:0];
          REG_P_BOUNDS: pb_q     <= cfg_data_i;
          REG_I_BOUNDS: ib_q     <= cfg_data_i;
          default:      mode_q   <= mode_q;
        endcase
      end
      integ_q <= integ_d;
      kp_q    <= kp_d;
      ki_q    <= ki_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      sp_q  <= setpoint_i;
      ms_q  <= measured_i;
      ts_q  <= time_step_i;
      gnd_q <= on_ground_i;
    end
    prod_q  <= prod_d;
    e_q     <= e_d;
    a_q     <= a_d;
    t_q     <= t_d;
    sg_q    <= sg_d;
    ilim_q  <= ilim_d;
    drive_q <= drive_d;
    nkp_q   <= nkp_d;
    sat_q   <= sat_d;
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    ma = '0;
    mb = '0;
    case (ctrl_i.op)
      OP_ERR:   begin ma = $signed({2'b0, lim_q}); mb = 33'(C40); end
      OP_ILIM:  begin ma = 33'(kp_q);  mb = 33'(e_q); end
      OP_T_PE:  begin ma = 33'(ki_q);  mb = 33'(integ_q); end
      OP_T_IE:  begin ma = 33'(e_q);   mb = $signed({17'b0, ts_q}); end
      OP_D_KI:  begin ma = 33'(ki_q);  mb = 33'(integ_q); end
      OP_SG:    begin ma = $signed({2'b0, leak_q}); mb = $signed({2'b0, rate_q}); end
      OP_GE:    begin ma = $signed({2'b0, rate_q}); mb = 33'(e_q); end
      OP_GEE:   begin ma = 33'(pq);    mb = 33'(e_q); end
      OP_SGKP:  begin ma = 33'(sg_q);  mb = 33'(kp_q); end
      OP_DKP:   begin ma = 33'(dsum);  mb = $signed({17'b0, ts_q}); end
      OP_GI:    begin ma = $signed({2'b0, rate_q}); mb = 33'(integ_q); end
      OP_GIE:   begin ma = 33'(pq);    mb = 33'(e_q); end
      OP_SGKI:  begin ma = 33'(sg_q);  mb = 33'(ki_q); end
      OP_DKI:   begin ma = 33'(dsum);  mb = $signed({17'b0, ts_q}); end
      default:  begin ma = '0; mb = '0; end
    endcase
  end

  assign dsum      = sat32(66'(t_q) - 66'(pq));
  assign prod_full = ma * mb;

  always_comb begin
    prod_d  = prod_full[63:0];
    integ_d = integ_q;
    kp_d    = kp_q;
    ki_d    = ki_q;
    e_d     = e_q;
    a_d     = a_q;
    t_d     = t_q;
    sg_d    = sg_q;
    ilim_d  = ilim_q;
    drive_d = drive_q;
    nkp_d   = nkp_q;
    sat_d   = sat_q;
    if (ctrl_i.load) begin
      drive_d = '0;
      sat_d   = 1'b0;
    end
    case (ctrl_i.op)
      OP_ERR:   e_d = sat32(66'(sp_q) - 66'(ms_q));
      OP_ILIM:  ilim_d = 32'(prod_q >>> FracBits);
      OP_T_PE:  a_d = pq;
      OP_T_IE:  begin
        t_d   = sat32(66'(a_q) + 66'(pq));
        sat_d = (t_d >= lim_s) || (t_d <= -lim_s);
        t_d   = pq; // keep a copy of qmul(ki, I) unused; trial only feeds flag
      end
      OP_INTEG: begin
        if (gnd_q) integ_d = '0;
        else if (!sat_q) integ_d = sat32(66'(integ_q) + 66'(pdt));
        integ_d = clamp32(integ_d, -ilim_q, ilim_q);
      end
      OP_DRIVE: drive_d = clamp32(sat32(66'(a_q) + 66'(pq)), -lim_s, lim_s);
      OP_GE:    sg_d = pq;
      OP_SGKP:  t_d = pq;
      OP_DKP:   t_d = dsum;
      OP_GI:    nkp_d = clamp32(sat32(66'(kp_q) + 66'(pdt)),
                                $signed(pb_q[31:0]), $signed(pb_q[63:32]));
      OP_SGKI:  t_d = pq;
      OP_NEWKI: begin
        kp_d = nkp_q;
        ki_d = clamp32(sat32(66'(ki_q) + 66'(pdt)),
                       $signed(ib_q[31:0]), $signed(ib_q[63:32]));
      end
      OP_FIXED: begin kp_d = KpFixed; ki_d = KiFixed; end
      OP_CLEAR: integ_d = '0;
      OP_RELOAD: begin
        kp_d = $signed({1'b0, init_p_q});
        ki_d = $signed({1'b0, init_i_q});
      end
      default: prod_d = prod_d;
    endcase
  end

  assign mode_o      = mode_q;
  assign drive_o     = drive_q;
  assign trial_sat_o = sat_q;
  assign p_gain_o    = kp_q;
  assign i_gain_o    = ki_q;

endmodule

// ===== tb/tb_adaptive_pi_controller.sv =====
// ---------------------------------------------------------------------------
// tb_adaptive_pi_controller
// Self-checking bench for the adaptive PI loop. A clocked driver streams
// command beats from a queue, a clocked monitor checks every result beat
// field by field against a cycle-free Q16.16 model of the loop, and the
// register port is exercised between phases across all gain modes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_adaptive_pi_controller;
  import apc_pkg::*;

  localparam int PhaseItems  = 230;
  localparam int HangLimit   = 5000;
  localparam int HoldCycles  = 400;
  localparam int DrainCycles = 40;

  typedef struct {
    cmd_e               cmd;
    logic signed [31:0] setpoint;
    logic signed [31:0] measured;
    logic [15:0]        time_step;
    logic               on_ground;
  } pi_cmd_t;

  typedef struct {
    logic signed [31:0] drive;
    logic               saturated;
    logic signed [31:0] p_gain;
    logic signed [31:0] i_gain;
  } pi_out_t;

  // Clock, reset and DUT ports; every input starts at a known value.
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  // Queues: beats still to send, and predicted results in arrival order.
  pi_cmd_t cmd_pending_q[$];
  pi_out_t drive_expect_q[$];
  pi_cmd_t cmd_on_bus;

  // Mirror of the loop state and register file.
  logic [63:0]        shadow_reg [8];
  logic signed [31:0] shadow_integ = '0;
  logic signed [31:0] shadow_kp = '0;
  logic signed [31:0] shadow_ki = '0;

  int  mismatch_cnt = 0;
  int  cfg_beats = 0;
  int  stall_cycles = 0;
  int  hold_req = 0;
  int  hold_seen = 0;
  int  hold_left = 0;
  bit  idle_en = 1'b1;

  adaptive_pi_controller u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point arithmetic of the loop
  // ---------------------------------------------------------------------------
  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Product in Q format, floored (arithmetic shift floors), then saturated.
  function automatic logic signed [31:0] qprod(logic signed [31:0] a,
                                               logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return clip32(p >>> FracBits);
  endfunction

  // Rate times dt; time_step is a 16-bit fraction of a second.
  function automatic logic signed [31:0] dt_scale(logic signed [31:0] a,
                                                  logic [15:0] ts);
    longint p;
    p = longint'(a) * longint'({48'd0, ts});
    return clip32(p >>> 16);
  endfunction

  // Raise to lo first, then lower to hi: crossed bounds let hi win.
  function automatic logic signed [31:0] bound(logic signed [31:0] x,
                                               logic signed [31:0] lo,
                                               logic signed [31:0] hi);
    if (x < lo) x = lo;
    if (x > hi) x = hi;
    return x;
  endfunction

  // Advance the mirrored loop by one command and return its result beat.
  function automatic pi_out_t pi_advance(pi_cmd_t c);
    pi_out_t            r;
    logic signed [31:0] lim, ilim, err, trial, g, sg, dkp, dki;
    mode_e              mode;
    r = '{drive: '0, saturated: 1'b0, p_gain: '0, i_gain: '0};
    case (c.cmd)
      CMD_STEP: begin
        lim   = {1'b0, shadow_reg[REG_LIMIT][30:0]};
        ilim  = 32'((longint'(lim) * longint'(C40)) >>> FracBits);
        err   = clip32(longint'(c.setpoint) - longint'(c.measured));
        trial = clip32(longint'(qprod(shadow_kp, err)) +
                       longint'(qprod(shadow_ki, shadow_integ)));
        r.saturated = (trial >= lim) || (trial <= -lim);
        // Landed holds the integral at zero; saturation skips integration.
        if (c.on_ground)
          shadow_integ = '0;
        else if (!r.saturated)
          shadow_integ = clip32(longint'(shadow_integ) +
                                longint'(dt_scale(err, c.time_step)));
        shadow_integ = bound(shadow_integ, -ilim, ilim);
        r.drive = clip32(longint'(qprod(shadow_kp, err)) +
                         longint'(qprod(shadow_ki, shadow_integ)));
        r.drive = bound(r.drive, -lim, lim);
        mode = mode_e'(shadow_reg[REG_MODE][1:0]);
        if (mode == MODE_ADAPT) begin
          g   = {1'b0, shadow_reg[REG_RATE][30:0]};
          sg  = qprod({1'b0, shadow_reg[REG_LEAK][30:0]}, g);
          dkp = clip32(longint'(qprod(qprod(g, err), err)) -
                       longint'(qprod(sg, shadow_kp)));
          dki = clip32(longint'(qprod(qprod(g, shadow_integ), err)) -
                       longint'(qprod(sg, shadow_ki)));
          shadow_kp = clip32(longint'(shadow_kp) + longint'(dt_scale(dkp, c.time_step)));
          shadow_ki = clip32(longint'(shadow_ki) + longint'(dt_scale(dki, c.time_step)));
          shadow_kp = bound(shadow_kp, shadow_reg[REG_P_BOUNDS][31:0],
                            shadow_reg[REG_P_BOUNDS][63:32]);
          shadow_ki = bound(shadow_ki, shadow_reg[REG_I_BOUNDS][31:0],
                            shadow_reg[REG_I_BOUNDS][63:32]);
        end else if (mode == MODE_FIXED) begin
          shadow_kp = KpFixed;
          shadow_ki = KiFixed;
        end
        // Frozen and the spare mode code leave the gains alone.
      end
      CMD_CLEAR:  shadow_integ = '0;
      CMD_RELOAD: begin
        shadow_kp = {1'b0, shadow_reg[REG_INIT_P][30:0]};
        shadow_ki = {1'b0, shadow_reg[REG_INIT_I][30:0]};
      end
      default: ;
    endcase
    r.p_gain = shadow_kp;
    r.i_gain = shadow_ki;
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present queued command beats; predict each one as it is taken.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    logic fire;
    fire = s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (fire) drive_expect_q.push_back(pi_advance(cmd_on_bus));
      if (!s_axis_tvalid || fire) begin
        if (cmd_pending_q.size() > 0 && !(idle_en && $urandom_range(99) < 29)) begin
          cmd_on_bus = cmd_pending_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {6'd0, cmd_on_bus.time_step, cmd_on_bus.measured,
                            cmd_on_bus.setpoint, cmd_on_bus.cmd};
          s_axis_tuser  <= cmd_on_bus.on_ground;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver backpressure; a requested hold-off is counted out here.
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !(idle_en && $urandom_range(99) < 29);
    end
  end

  // Monitor: compare each result beat with the oldest prediction.
  always @(posedge clk_i) begin
    pi_out_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (drive_expect_q.size() == 0) begin
        report_mismatch("result beat with nothing outstanding");
      end else begin
        want = drive_expect_q.pop_front();
        if ($signed(m_axis_tdata[31:0]) != want.drive)
          report_mismatch($sformatf("drive %h want %h", m_axis_tdata[31:0], want.drive));
        if (m_axis_tuser != want.saturated)
          report_mismatch($sformatf("trial_saturated %b want %b", m_axis_tuser,
                                    want.saturated));
        if ($signed(m_axis_tdata[63:32]) != want.p_gain)
          report_mismatch($sformatf("p_gain %h want %h", m_axis_tdata[63:32], want.p_gain));
        if ($signed(m_axis_tdata[95:64]) != want.i_gain)
          report_mismatch($sformatf("i_gain %h want %h", m_axis_tdata[95:64], want.i_gain));
      end
    end
  end

  // Register beats update the shadow copy as they are taken.
  always @(posedge clk_i) begin
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i <= REG_LIMIT)
        shadow_reg[cfg_index_i] = {33'd0, cfg_data_i[30:0]};
      else if (cfg_index_i == REG_MODE)
        shadow_reg[cfg_index_i] = {62'd0, cfg_data_i[1:0]};
      else
        shadow_reg[cfg_index_i] = cfg_data_i;
      cfg_beats <= cfg_beats + 1;
    end
  end

  // Watchdog: end the run when no channel moves for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= HangLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_cmd(cmd_e c, logic signed [31:0] sp, logic signed [31:0] ms,
                         logic [15:0] ts, logic gnd);
    cmd_pending_q.push_back('{cmd: c, setpoint: sp, measured: ms, time_step: ts,
                              on_ground: gnd});
  endtask

  // Mostly plant-sized values around zero, sometimes full range or extremes.
  function automatic logic signed [31:0] rand_q();
    case ($urandom_range(9))
      6, 7:    return $urandom;
      8:       return 32'sh7FFFFFFF;
      9:       return 32'sh80000000;
      default: return $signed($urandom_range(0, 20 << 16)) - (10 << 16);
    endcase
  endfunction

  task automatic add_random_cmd();
    int   pick;
    cmd_e c;
    pick = $urandom_range(99);
    c = (pick < 80) ? CMD_STEP : (pick < 87) ? CMD_CLEAR :
        (pick < 94) ? CMD_RELOAD : CMD_NOP;
    add_cmd(c, rand_q(), rand_q(),
            ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1500)),
            $urandom_range(9) == 0);
  endtask

  // Hold the bus at a rising edge until the write beat is taken.
  task automatic reg_write(reg_e idx, logic [63:0] val);
    int n;
    n = cfg_beats + 1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    wait (cfg_beats == n);
  endtask

  // Pause the sender until every predicted result has come back.
  task automatic drain();
    while (cmd_pending_q.size() != 0 || s_axis_tvalid || drive_expect_q.size() != 0)
      @(posedge clk_i);
  endtask

  // Write every register; unused upper bits carry junk to test masking.
  task automatic load_regs(logic [30:0] kp0, logic [30:0] ki0, logic [30:0] rate,
                           logic [30:0] leak, logic [30:0] lim, logic [1:0] mode,
                           logic [63:0] pb, logic [63:0] ib);
    reg_write(REG_INIT_P, {$urandom, 1'b0, kp0} ^ {33'h1_FFFF_FFFF & $urandom, 31'd0});
    reg_write(REG_INIT_I, {33'($urandom), ki0});
    reg_write(REG_RATE, {33'($urandom), rate});
    reg_write(REG_LEAK, {33'($urandom), leak});
    reg_write(REG_LIMIT, {33'($urandom), lim});
    reg_write(REG_MODE, {62'($urandom), mode});
    reg_write(REG_P_BOUNDS, pb);
    reg_write(REG_I_BOUNDS, ib);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [63:0] rand_bounds();
    logic signed [31:0] lo, hi;
    lo = $signed($urandom_range(0, 8 << 16)) - (2 << 16);
    hi = lo + $signed($urandom_range(0, 60 << 16));
    if ($urandom_range(5) == 0) return {lo - 32'sd1000, lo};  // crossed
    if ($urandom_range(5) == 0) return {32'sh7FFFFFFF, 32'sh80000000};
    return {hi, lo};
  endfunction

  function automatic logic [30:0] rand_small(int top);
    return 31'($urandom_range(0, top));
  endfunction

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero output limit: every step counts as saturated, drive stays 0.
    load_regs(31'(2 << 16), 31'(1 << 15), '0, '0, '0, MODE_FROZEN,
              {32'sh7FFFFFFF, 32'sh80000000}, {32'sh7FFFFFFF, 32'sh80000000});
    add_cmd(CMD_STEP, 32'sd0, 32'sd0, 16'hFFFF, 1'b0);
    add_cmd(CMD_RELOAD, '0, '0, '0, 1'b0);
    add_cmd(CMD_STEP, 32'(3 << 16), 32'sd0, 16'hFFFF, 1'b0);
    add_cmd(CMD_STEP, 32'sh80000000, 32'sh7FFFFFFF, 16'h8000, 1'b0);
    drain();

    // Directed extremes with a sane limit, fixed gains.
    load_regs(31'(2 << 16), 31'(1 << 15), 31'(1 << 12), 31'(1 << 14), 31'(100 << 16),
              MODE_FIXED, {32'(50 << 16), 32'sd0}, {32'(20 << 16), 32'sd0});
    add_cmd(CMD_STEP, 32'sd0, 32'sd0, 16'hFFFF, 1'b0);
    add_cmd(CMD_STEP, 32'sh7FFFFFFF, 32'sh80000000, 16'hFFFF, 1'b0);
    add_cmd(CMD_STEP, 32'sh80000000, 32'sh7FFFFFFF, 16'hFFFF, 1'b0);
    add_cmd(CMD_STEP, 32'(1 << 16), 32'sd0, 16'h0000, 1'b0);
    add_cmd(CMD_STEP, 32'(1 << 16), 32'sd0, 16'h0CCC, 1'b0);
    add_cmd(CMD_STEP, -32'sd65536, 32'sd0, 16'h0CCC, 1'b0);
    add_cmd(CMD_STEP, 32'(1 << 16), 32'sd0, 16'h0CCC, 1'b1);
    add_cmd(CMD_STEP, 32'(1 << 16), 32'sd0, 16'hFFFF, 1'b0);
    add_cmd(CMD_CLEAR, 32'sh7FFFFFFF, 32'sh80000000, 16'hFFFF, 1'b1);
    add_cmd(CMD_NOP, 32'sh80000000, 32'sh7FFFFFFF, 16'hFFFF, 1'b1);
    add_cmd(CMD_RELOAD, '0, '0, '0, 1'b0);
    add_cmd(CMD_STEP, 32'(10 << 16), 32'(2 << 16), 16'h1000, 1'b0);
    drain();

    // Random phases cycling through all four mode codes and varied limits.
    for (int ph = 0; ph < 8; ph++) begin
      idle_en = (ph != 2);
      case (ph)
        4: load_regs('1, '1, '1, '1, '1, MODE_ADAPT,
                     {32'sh7FFFFFFF, 32'sh80000000}, {32'sh7FFFFFFF, 32'sh80000000});
        5: load_regs('0, '0, '0, '0, '0, MODE_ADAPT, '0, '0);
        default:
          load_regs(rand_small(30 << 16), rand_small(10 << 16), rand_small(1 << 14),
                    rand_small(1 << 15),
                    ($urandom_range(4) == 0) ? 31'h7FFFFFFF : rand_small(300 << 16),
                    2'(ph % 4), rand_bounds(), rand_bounds());
      endcase
      add_cmd(CMD_RELOAD, '0, '0, '0, 1'b0);
      for (int k = 0; k < PhaseItems; k++) add_random_cmd();
      if (ph == 1) hold_req = hold_req + 1;
      drain();
    end

    repeat (DrainCycles) @(posedge clk_i);
    while (drive_expect_q.size() > 0) begin
      void'(drive_expect_q.pop_front());
      report_mismatch("predicted result never arrived");
    end
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
